// File: hdl/ils_pkg.sv
// Package for the integer list sorter: sizes, the cell data and command types,
// and the state codes of the controller.
// Depends on nothing; every other file in hdl uses it.
package ils_pkg;

   localparam int VALUE_W      = 32;
   localparam int MAX_ELEMENTS = 64;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   typedef logic signed [VALUE_W-1:0] value_type;

   // What one cell of the chain hands to its neighbors.
   typedef struct packed {
      logic      valid;
      value_type value;
      logic      goes_after; // the value being inserted belongs at or before this cell
   } cell_link_type;

   // Command broadcast to every cell in a cycle.
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_SHIFT_LEFT,
      CMD_SHIFT_RIGHT
   } cell_cmd_type;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } fsm_state_type;

endpackage

// File: hdl/ils_if.sv
// Valid/ready channel interfaces for the list sorter: request items and
// response items. Depends on ils_pkg for the value width.
interface ils_req_if;
   logic                     valid;
   logic                     ready;
   logic signed [ils_pkg::VALUE_W-1:0] element_value;
   logic                     is_last;

   modport source (output valid, output element_value, output is_last, input ready);
   modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface ils_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [ils_pkg::VALUE_W-1:0] sorted_value;
   logic                     last_of_run;
   logic                     overflow;

   modport source (output valid, output sorted_value, output last_of_run, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_of_run, input overflow,
                   output ready);
endinterface

// File: hdl/ils_cell.sv
// One cell of the sorting chain: holds one value and its valid bit, and
// inserts or shifts under a broadcast command. Depends on ils_pkg.
module ils_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ils_pkg::cell_cmd_type cmd,
   input  ils_pkg::value_type    ins_value,
   input  ils_pkg::cell_link_type left_i,
   input  ils_pkg::cell_link_type right_i,
   output ils_pkg::cell_link_type link_o
);
   import ils_pkg::*;

   logic      valid_ff, valid_in;
   value_type value_ff, value_in;
   logic      goes_after;

   // The new value goes here when this cell is empty or holds a larger value.
   assign goes_after = !valid_ff || (value_ff > ins_value);

   assign link_o = '{valid: valid_ff, value: value_ff, goes_after: goes_after};

   // Next cell contents for each command.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (cmd)
         CMD_INSERT: begin
            if (goes_after) begin
               if (left_i.goes_after) begin
                  // The insertion point lies further left: take the left neighbor.
                  valid_in = left_i.valid;
                  value_in = left_i.value;
               end else begin
                  valid_in = 1'b1;
                  value_in = ins_value;
               end
            end
         end
         CMD_SHIFT_LEFT: begin
            valid_in = right_i.valid;
            value_in = right_i.value;
         end
         CMD_SHIFT_RIGHT: begin
            valid_in = left_i.valid;
            value_in = left_i.value;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   // The valid bit is control state; the value is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: hdl/integer_list_sorter.sv
// Top level of the integer list sorter: controller plus a chain of
// ils_cell instances. Depends on ils_pkg, ils_if.sv and ils_cell.sv.
//
//   Channel | Direction | Handshake    | Carries
//   req_ch  | in        | valid/ready  | element_value, is_last
//   rsp_ch  | out       | valid/ready  | sorted_value, last_of_run, overflow
//   csr_*   | in        | write enable | ascending (1 bit)
//
// Each item is inserted in sorted place in the cell chain as it is taken; once
// the chain is full, further items are dropped and overflow is set. After the
// last item, results leave at one per cycle while the response is not stalled;
// in descending order the chain first shifts to its far end until the tail is
// filled. New items are taken only while loading. Reset is synchronous and empties
// the chain; ascending resets to 1. A stalled response holds the chain unchanged.
module integer_list_sorter (
   input  logic          clock,
   input  logic          reset,
   ils_req_if.sink       req_ch,
   ils_rsp_if.source     rsp_ch,
   input  logic          csr_we,
   input  logic          csr_wdata
);
   import ils_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam cell_link_type EMPTY_LINK = '{valid: 1'b0, value: '0, goes_after: 1'b0};

   fsm_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             dropped_ff, dropped_in;
   logic             ascending_ff, ascending_in;
   logic             dir_ff, dir_in;
   cell_cmd_type     cmd;
   cell_link_type    links [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] valid_vec;
   logic             req_take, rsp_take, full, tail_valid;

   // Configuration register.
   always_comb begin
      ascending_in = csr_we ? csr_wdata : ascending_ff;
   end

   // Cell chain.
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      cell_link_type left_link, right_link;
      if (i == 0) begin : g_head
         assign left_link = EMPTY_LINK;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign right_link = EMPTY_LINK;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end
      ils_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .ins_value (req_ch.element_value),
         .left_i    (left_link),
         .right_i   (right_link),
         .link_o    (links[i])
      );
      assign valid_vec[i] = links[i].valid;
   end

   assign full       = (cnt_ff == MAX_CNT);
   assign tail_valid = links[MAX_ELEMENTS-1].valid;

   // Handshakes and response payload.
   assign req_ch.ready       = (state_ff == ST_LOAD);
   assign req_take           = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid       = (state_ff == ST_EMIT) && (dir_ff ? links[0].valid : tail_valid);
   assign rsp_take           = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.sorted_value = dir_ff ? links[0].value : links[MAX_ELEMENTS-1].value;
   assign rsp_ch.last_of_run = (cnt_ff == ONE_CNT);
   assign rsp_ch.overflow    = dropped_ff;

   // Controller: chain command, count, flags and state.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      dropped_in = dropped_ff;
      dir_in     = dir_ff;
      cmd        = CMD_HOLD;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cmd    = CMD_INSERT;
                  cnt_in = cnt_ff + ONE_CNT;
               end
               if (req_ch.is_last) begin
                  dir_in   = ascending_ff;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (dir_ff) begin
               if (rsp_take) begin
                  cmd = CMD_SHIFT_LEFT;
               end
            end else if (rsp_take || !tail_valid) begin
               // Pop the tail, or move the list toward the tail until it is there.
               cmd = CMD_SHIFT_RIGHT;
            end
            if (rsp_take) begin
               cnt_in = cnt_ff - ONE_CNT;
               if (rsp_ch.last_of_run) begin
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         dropped_ff   <= 1'b0;
         ascending_ff <= 1'b1;
         dir_ff       <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dropped_ff   <= dropped_in;
         ascending_ff <= ascending_in;
         dir_ff       <= dir_in;
      end
   end

   // The count never passes the chain length.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("stored count exceeds chain length");

   // While loading, the chain holds exactly as many values as the count says.
   a_cnt_matches: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> $countones(valid_vec) == int'(cnt_ff))
      else $error("chain occupancy differs from stored count");

   // The head of the chain is kept in ascending order.
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (links[0].valid && links[1].valid && state_ff == ST_LOAD)
         |-> links[0].value <= links[1].value)
      else $error("chain head out of order");

   // Taking the final response returns the block to loading with an empty chain.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_ch.last_of_run) |=> (state_ff == ST_LOAD && valid_vec == '0))
      else $error("run did not end cleanly");

endmodule
